>>> rtl/rrsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrsp_pkg;

    localparam int CHAN_BITS   = 8;
    localparam int COLOR_BITS  = 24;
    localparam int WIDTH_BITS  = 12;
    localparam int RADIUS_BITS = 11;
    localparam int SHADOW_BITS = 8;
    localparam int ADDR_BITS   = 5;
    localparam int DATA_BITS   = 32;

    typedef enum logic [2:0] {
        REG_RECT_WIDTH       = 3'd0,
        REG_RECT_HEIGHT      = 3'd1,
        REG_CORNER_RADIUS    = 3'd2,
        REG_SHADOW_WIDTH     = 3'd3,
        REG_FILL_COLOR       = 3'd4,
        REG_SHADOW_COLOR     = 3'd5,
        REG_BACKGROUND_COLOR = 3'd6
    } reg_idx_t;

    // How the final color of a pixel is formed.
    typedef enum logic [1:0] {
        PIX_FILL       = 2'd0,
        PIX_NEAR       = 2'd1,
        PIX_BACKGROUND = 2'd2,
        PIX_FALLOFF    = 2'd3
    } pix_class_t;

endpackage

`default_nettype wire

>>> rtl/rrsp_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined integer square root, one result bit per stage.
module rrsp_isqrt #(
    parameter int NR = 16
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [2*NR-1:0]   radicand,
    output logic      [NR-1:0]     root
);

    logic [NR+1:0]   rem_reg  [NR-1];
    logic [2*NR-1:0] rest_reg [NR-1];
    logic [NR-1:0]   root_reg [NR];

    genvar k;
    generate
        for (k = 0; k < NR; k++) begin : g_stage
            logic [NR+1:0]   rem_in;
            logic [NR-1:0]   root_in;
            logic [2*NR-1:0] rest_in;
            logic [NR+1:0]   remx;
            logic [NR+1:0]   trial;
            logic            ge;
            logic [NR+1:0]   rem_next;

            if (k == 0) begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign rest_in = radicand;
            end
            else begin : g_rest
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign rest_in = rest_reg[k-1];
            end

            assign remx     = {rem_in[NR-1:0], rest_in[2*NR-1:2*NR-2]};
            assign trial    = {root_in, 2'b01};
            assign ge       = (remx >= trial);
            assign rem_next = ge ? (remx - trial) : remx;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    root_reg[k] <= {root_in[NR-2:0], ge};
                end
            end

            if (k < NR - 1) begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[k]  <= rem_next;
                        rest_reg[k] <= {rest_in[2*NR-3:0], 2'b00};
                    end
                end
            end
        end
    endgenerate

    assign root = root_reg[NR-1];

endmodule

`default_nettype wire

>>> rtl/rounded_rect_shadow_pixel.sv
`timescale 1ns / 1ps
`default_nettype none

// The pipeline runs through two pipelined square roots and the quotient stages.
// Throughput: one pixel word per clock; the whole pipeline holds while the output
// word is stalled. Reset (rst_n, asynchronous, active low) clears all valid bits
// and sets every configuration register to zero.
module rounded_rect_shadow_pixel #(
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [rrsp_pkg::ADDR_BITS-1:0]      paddr,
    input  wire logic [rrsp_pkg::DATA_BITS-1:0]      pwdata,
    output logic      [rrsp_pkg::DATA_BITS-1:0]      prdata,
    output logic                                     pready,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [COORD_BITS-1:0]        pixel_x,
    input  wire logic signed [COORD_BITS-1:0]        pixel_y,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic      [rrsp_pkg::COLOR_BITS-1:0]     pixel_color
);

    localparam int CB  = COORD_BITS;
    localparam int FB  = FRAC_BITS;
    localparam int GW  = (CB > rrsp_pkg::WIDTH_BITS + 1) ? CB : rrsp_pkg::WIDTH_BITS + 1;
    localparam int DW  = GW + 2;
    localparam int SQW = 2 * DW;
    localparam int NR  = DW + FB;
    localparam int DFW = CB + FB;
    localparam int MW  = FB + rrsp_pkg::SHADOW_BITS;
    localparam int NW  = 2 * MW;
    localparam int TW  = FB + 1;
    localparam int CHB = rrsp_pkg::CHAN_BITS;
    localparam int PW  = CHB + TW;
    localparam int RRW = 2 * rrsp_pkg::RADIUS_BITS;
    localparam int COLW = rrsp_pkg::COLOR_BITS;

    localparam logic [DFW-1:0]       DMAX  = '1;
    localparam logic [DFW-1:0]       ONE_D = DFW'({1'b1, {FB{1'b0}}});
    localparam logic [MW-1:0]        ONE_M = MW'({1'b1, {FB{1'b0}}});
    localparam logic [TW-1:0]        ONE_T = {1'b1, {FB{1'b0}}};
    localparam logic signed [DW-1:0] ONE_S = DW'(1);
    localparam logic signed [DW-1:0] ZERO_S = '0;

    typedef struct packed {
        logic          fill;
        logic          edge_hit;
        logic [CB-1:0] d;
    } sb1_t;

    typedef struct packed {
        rrsp_pkg::pix_class_t cls;
        logic [FB-1:0]        tlow;
    } sb2_t;

    // ---------------- configuration registers ----------------
    logic [rrsp_pkg::WIDTH_BITS-1:0]  width_reg;
    logic [rrsp_pkg::WIDTH_BITS-1:0]  height_reg;
    logic [rrsp_pkg::RADIUS_BITS-1:0] radius_reg;
    logic [rrsp_pkg::SHADOW_BITS-1:0] shadow_reg;
    logic [COLW-1:0]                  fill_reg;
    logic [COLW-1:0]                  shcol_reg;
    logic [COLW-1:0]                  bg_reg;
    rrsp_pkg::reg_idx_t               reg_idx;
    logic                             wr_en;

    assign reg_idx = rrsp_pkg::reg_idx_t'(paddr[rrsp_pkg::ADDR_BITS-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
            radius_reg <= '0;
            shadow_reg <= '0;
            fill_reg   <= '0;
            shcol_reg  <= '0;
            bg_reg     <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                rrsp_pkg::REG_RECT_WIDTH:       width_reg  <= pwdata[rrsp_pkg::WIDTH_BITS-1:0];
                rrsp_pkg::REG_RECT_HEIGHT:      height_reg <= pwdata[rrsp_pkg::WIDTH_BITS-1:0];
                rrsp_pkg::REG_CORNER_RADIUS:    radius_reg <= pwdata[rrsp_pkg::RADIUS_BITS-1:0];
                rrsp_pkg::REG_SHADOW_WIDTH:     shadow_reg <= pwdata[rrsp_pkg::SHADOW_BITS-1:0];
                rrsp_pkg::REG_FILL_COLOR:       fill_reg   <= pwdata[COLW-1:0];
                rrsp_pkg::REG_SHADOW_COLOR:     shcol_reg  <= pwdata[COLW-1:0];
                rrsp_pkg::REG_BACKGROUND_COLOR: bg_reg     <= pwdata[COLW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            rrsp_pkg::REG_RECT_WIDTH:       prdata = rrsp_pkg::DATA_BITS'(width_reg);
            rrsp_pkg::REG_RECT_HEIGHT:      prdata = rrsp_pkg::DATA_BITS'(height_reg);
            rrsp_pkg::REG_CORNER_RADIUS:    prdata = rrsp_pkg::DATA_BITS'(radius_reg);
            rrsp_pkg::REG_SHADOW_WIDTH:     prdata = rrsp_pkg::DATA_BITS'(shadow_reg);
            rrsp_pkg::REG_FILL_COLOR:       prdata = rrsp_pkg::DATA_BITS'(fill_reg);
            rrsp_pkg::REG_SHADOW_COLOR:     prdata = rrsp_pkg::DATA_BITS'(shcol_reg);
            rrsp_pkg::REG_BACKGROUND_COLOR: prdata = rrsp_pkg::DATA_BITS'(bg_reg);
            default:                        prdata = '0;
        endcase
    end

    // ---------------- pipeline enable ----------------
    logic out_valid_reg;
    logic en;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // ---------------- stage A: geometry ----------------
    logic signed [DW-1:0] xs, ys, wv, hv, rv, xlim, ylim, cx, cy, d_raw;
    logic xband, yband, fill_a, edge_a;

    assign xs   = {{(DW-CB){pixel_x[CB-1]}}, pixel_x};
    assign ys   = {{(DW-CB){pixel_y[CB-1]}}, pixel_y};
    assign wv   = DW'(width_reg);
    assign hv   = DW'(height_reg);
    assign rv   = DW'(radius_reg);
    assign xlim = wv - rv;
    assign ylim = hv - rv;

    assign xband  = (rv <= xs) && (xs < xlim);
    assign yband  = (rv <= ys) && (ys < ylim);
    assign fill_a = (xband && !ys[DW-1] && (ys < hv)) || (!xs[DW-1] && (xs < wv) && yband);

    always_comb
    begin
        edge_a = 1'b0;
        d_raw  = '0;
        if (ys[DW-1])
        begin
            edge_a = xband;
            d_raw  = ZERO_S - ys;
        end
        else if (ys > hv)
        begin
            edge_a = xband;
            d_raw  = ys - hv + ONE_S;
        end
        else if (xs[DW-1])
        begin
            edge_a = yband;
            d_raw  = ZERO_S - xs;
        end
        else if (xs > wv)
        begin
            edge_a = yband;
            d_raw  = xs - wv + ONE_S;
        end
    end

    // The corner center on the right or bottom is chosen from the half point.
    assign cx = (xs < $signed({1'b0, wv[DW-1:1]})) ? rv : (xlim - ONE_S);
    assign cy = (ys < $signed({1'b0, hv[DW-1:1]})) ? rv : (ylim - ONE_S);

    logic                 a_valid_reg;
    logic                 a_fill_reg, a_edge_reg;
    logic [CB-1:0]        a_d_reg;
    logic signed [DW-1:0] a_dx_reg, a_dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_fill_reg <= fill_a;
            a_edge_reg <= edge_a;
            a_d_reg    <= d_raw[CB-1:0];
            a_dx_reg   <= xs - cx;
            a_dy_reg   <= ys - cy;
        end
    end

    // ---------------- stage B: squares ----------------
    logic           b_valid_reg;
    logic           b_fill_reg, b_edge_reg;
    logic [CB-1:0]  b_d_reg;
    logic [SQW-1:0] b_sqx_reg, b_sqy_reg;
    logic [RRW-1:0] b_rr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_fill_reg <= a_fill_reg;
            b_edge_reg <= a_edge_reg;
            b_d_reg    <= a_d_reg;
            b_sqx_reg  <= a_dx_reg * a_dx_reg;
            b_sqy_reg  <= a_dy_reg * a_dy_reg;
            b_rr_reg   <= RRW'(radius_reg) * RRW'(radius_reg);
        end
    end

    // ---------------- stage C: squared distance, corner test ----------------
    logic [SQW-1:0] sq_next;
    logic           c_valid_reg;
    sb1_t           c_sb_reg;
    logic [SQW-1:0] c_sq_reg;

    assign sq_next = b_sqx_reg + b_sqy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_sb_reg.fill     <= b_fill_reg || (!b_edge_reg && (sq_next <= SQW'(b_rr_reg)));
            c_sb_reg.edge_hit <= b_edge_reg;
            c_sb_reg.d        <= b_d_reg;
            c_sq_reg          <= sq_next;
        end
    end

    // ---------------- corner distance square root ----------------
    logic [NR-1:0] root1;
    logic [NR-1:0] v1_reg;
    sb1_t          sb1_reg [NR];

    rrsp_isqrt #(
        .NR (NR)
    ) u_sqrt_dist (
        .clk      (clk),
        .en       (en),
        .radicand ({c_sq_reg, {(2*FB){1'b0}}}),
        .root     (root1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= '0;
        end
        else if (en)
        begin
            v1_reg <= {v1_reg[NR-2:0], c_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb1_reg[0] <= c_sb_reg;
            for (int i = 1; i < NR; i++)
            begin
                sb1_reg[i] <= sb1_reg[i-1];
            end
        end
    end

    // ---------------- stage D: fixed-point distance and class ----------------
    sb1_t                 sbd;
    logic [NR-1:0]        dist_fx;
    logic [DFW-1:0]       dfx_next;
    rrsp_pkg::pix_class_t cls_next;
    logic                 d_valid_reg;
    rrsp_pkg::pix_class_t d_cls_reg;
    logic [DFW-1:0]       d_dfx_reg;

    assign sbd  = sb1_reg[NR-1];
    assign dist_fx = sbd.edge_hit ? NR'({sbd.d, {FB{1'b0}}})
                                  : (root1 - NR'({radius_reg, {FB{1'b0}}}));
    assign dfx_next = (dist_fx > NR'(DMAX)) ? DMAX : dist_fx[DFW-1:0];

    always_comb
    begin
        if (sbd.fill)
        begin
            cls_next = rrsp_pkg::PIX_FILL;
        end
        else if (dfx_next < ONE_D)
        begin
            cls_next = rrsp_pkg::PIX_NEAR;
        end
        else if ((shadow_reg == '0) || (dfx_next > DFW'({shadow_reg, {FB{1'b0}}})))
        begin
            cls_next = rrsp_pkg::PIX_BACKGROUND;
        end
        else
        begin
            cls_next = rrsp_pkg::PIX_FALLOFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= v1_reg[NR-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_cls_reg <= cls_next;
            d_dfx_reg <= dfx_next;
        end
    end

    // ---------------- stage E: falloff squares ----------------
    logic [MW-1:0]        full_m, m_next;
    logic                 e_valid_reg;
    sb2_t                 e_sb_reg;
    logic [NW-1:0]        e_msq_reg, e_fsq_reg;

    assign full_m = {shadow_reg, {FB{1'b0}}};
    // In the falloff band one <= d <= S, so m stays within MW bits.
    assign m_next = full_m - d_dfx_reg[MW-1:0] + ONE_M;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_sb_reg.cls  <= d_cls_reg;
            e_sb_reg.tlow <= d_dfx_reg[FB-1:0];
            e_msq_reg     <= NW'(m_next) * NW'(m_next);
            e_fsq_reg     <= NW'(full_m) * NW'(full_m);
        end
    end

    // ---------------- stage F: difference of squares ----------------
    logic          f_valid_reg;
    sb2_t          f_sb_reg;
    logic [NW-1:0] f_n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_sb_reg <= e_sb_reg;
            f_n_reg  <= e_fsq_reg - e_msq_reg;
        end
    end

    // ---------------- falloff square root ----------------
    logic [MW-1:0] root2;
    logic [MW-1:0] v2_reg;
    sb2_t          sb2_reg [MW];

    rrsp_isqrt #(
        .NR (MW)
    ) u_sqrt_fall (
        .clk      (clk),
        .en       (en),
        .radicand (f_n_reg),
        .root     (root2)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= '0;
        end
        else if (en)
        begin
            v2_reg <= {v2_reg[MW-2:0], f_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb2_reg[0] <= f_sb_reg;
            for (int i = 1; i < MW; i++)
            begin
                sb2_reg[i] <= sb2_reg[i-1];
            end
        end
    end

    // ---------------- quotient by shadow width, one bit per stage ----------------
    // The root never exceeds S * one, so the quotient fits in FRAC_BITS + 1 bits.
    logic [MW-1:0] qr_reg [TW-1];
    logic [TW-1:0] qq_reg [TW];
    logic [TW-1:0] v3_reg;
    sb2_t          sb3_reg [TW];

    genvar j;
    generate
        for (j = 0; j < TW; j++) begin : g_div
            logic [MW-1:0] rem_in;
            logic [TW-1:0] q_in;
            logic [MW-1:0] dv;
            logic          ge;

            if (j == 0) begin : g_first
                assign rem_in = root2;
                assign q_in   = '0;
            end
            else begin : g_rest
                assign rem_in = qr_reg[j-1];
                assign q_in   = qq_reg[j-1];
            end

            assign dv = MW'(shadow_reg) << (FB - j);
            assign ge = (rem_in >= dv);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    qq_reg[j] <= {q_in[TW-2:0], ge};
                end
            end

            if (j < TW - 1) begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        qr_reg[j] <= ge ? (rem_in - dv) : rem_in;
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= '0;
        end
        else if (en)
        begin
            v3_reg <= {v3_reg[TW-2:0], v2_reg[MW-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb3_reg[0] <= sb2_reg[MW-1];
            for (int i = 1; i < TW; i++)
            begin
                sb3_reg[i] <= sb3_reg[i-1];
            end
        end
    end

    // ---------------- stage G: pick colors and blend factor ----------------
    sb2_t            sbg;
    logic [COLW-1:0] c1_next, c2_next;
    logic [TW-1:0]   t_next;
    logic            g_valid_reg;
    logic [COLW-1:0] g_c1_reg, g_c2_reg;
    logic [TW-1:0]   g_t_reg;

    assign sbg = sb3_reg[TW-1];

    always_comb
    begin
        case (sbg.cls)
            rrsp_pkg::PIX_FILL:
            begin
                c1_next = fill_reg;
                c2_next = fill_reg;
                t_next  = '0;
            end
            rrsp_pkg::PIX_NEAR:
            begin
                c1_next = fill_reg;
                c2_next = (shadow_reg == '0) ? bg_reg : shcol_reg;
                t_next  = {1'b0, sbg.tlow};
            end
            rrsp_pkg::PIX_FALLOFF:
            begin
                c1_next = shcol_reg;
                c2_next = bg_reg;
                t_next  = qq_reg[TW-1];
            end
            default:
            begin
                c1_next = bg_reg;
                c2_next = bg_reg;
                t_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            g_valid_reg <= v3_reg[TW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_c1_reg <= c1_next;
            g_c2_reg <= c2_next;
            g_t_reg  <= t_next;
        end
    end

    // ---------------- stage H: channel products, then output word ----------------
    logic            h_valid_reg;
    logic [PW-1:0]   h_pa_reg [3];
    logic [PW-1:0]   h_pb_reg [3];
    logic [COLW-1:0] color_next;
    logic [COLW-1:0] out_color_reg;

    genvar c;
    generate
        for (c = 0; c < 3; c++) begin : g_chan
            logic [PW:0] sum;

            assign sum = {1'b0, h_pa_reg[c]} + {1'b0, h_pb_reg[c]};
            assign color_next[c*CHB +: CHB] = sum[FB +: CHB];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    h_pa_reg[c] <= PW'(g_c1_reg[c*CHB +: CHB]) * PW'(ONE_T - g_t_reg);
                    h_pb_reg[c] <= PW'(g_c2_reg[c*CHB +: CHB]) * PW'(g_t_reg);
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            h_valid_reg   <= g_valid_reg;
            out_valid_reg <= h_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_color_reg <= color_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = out_color_reg;

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import rrsp_pkg::*;

    localparam int COORD_BITS = 13;
    localparam int FRAC_BITS  = 8;
    localparam int LATENCY    = 3 * FRAC_BITS + COORD_BITS + 20;
    localparam int IDLE_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [COORD_BITS-1:0] pixel_x = '0, pixel_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [COLOR_BITS-1:0] pixel_color;

    rounded_rect_shadow_pixel #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) uut (.*);

    initial begin
        forever #5 clk = ~clk;
    end

    int errors = 0;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // Shadow copy of the configuration registers.
    logic [WIDTH_BITS-1:0]  cfg_w, cfg_h;
    logic [RADIUS_BITS-1:0] cfg_r;
    logic [SHADOW_BITS-1:0] cfg_s;
    logic [COLOR_BITS-1:0]  cfg_fill, cfg_shadow, cfg_bg;

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [23:0] mix(input logic [23:0] c1, input logic [23:0] c2,
                                        input longint unsigned t);
        longint unsigned one, a, b, ch;
        logic [23:0] res;
        one = 64'd1 << FRAC_BITS;
        if (t > one) t = one;
        for (int s = 0; s < 24; s += 8) begin
            a = (c1 >> s) & 8'hff;
            b = (c2 >> s) & 8'hff;
            ch = ((a * (one - t) + b * t) >> FRAC_BITS) & 8'hff;
            res[s+:8] = ch[7:0];
        end
        return res;
    endfunction

    function automatic logic [23:0] shade_pixel(input logic signed [COORD_BITS-1:0] px,
                                                input logic signed [COORD_BITS-1:0] py);
        longint x, y, wd, ht, rad, d, cx, cy, dx, dy;
        longint unsigned sw, one, dmax, dfx, sq, full, m, n, t;
        bit xb, yb;
        x = px; y = py;
        wd = cfg_w; ht = cfg_h; rad = cfg_r; sw = cfg_s;
        one = 64'd1 << FRAC_BITS;
        dmax = (64'd1 << (COORD_BITS + FRAC_BITS)) - 1;
        xb = (rad <= x) && (x < wd - rad);
        yb = (rad <= y) && (y < ht - rad);
        d = -1;
        if ((xb && y >= 0 && y < ht) || (x >= 0 && x < wd && yb)) return cfg_fill;
        if (y < 0) begin
            if (xb) d = -y;
        end else if (y > ht) begin
            if (xb) d = y - ht + 1;
        end else if (x < 0) begin
            if (yb) d = -x;
        end else if (x > wd) begin
            if (yb) d = x - wd + 1;
        end
        if (d >= 0) begin
            dfx = d << FRAC_BITS;
        end else begin
            cx = (x < wd / 2) ? rad : wd - rad - 1;
            cy = (y < ht / 2) ? rad : ht - rad - 1;
            dx = x - cx;
            dy = y - cy;
            sq = dx * dx + dy * dy;
            if (sq <= rad * rad) return cfg_fill;
            dfx = int_sqrt(sq << (2 * FRAC_BITS)) - (rad << FRAC_BITS);
        end
        if (dfx > dmax) dfx = dmax;
        if (dfx < one) return mix(cfg_fill, sw == 0 ? cfg_bg : cfg_shadow, dfx);
        if (sw == 0 || dfx > (sw << FRAC_BITS)) return cfg_bg;
        full = sw * one;
        m = full - (dfx - one);
        n = full * full - m * m;
        t = int_sqrt(n) / sw;
        return mix(cfg_shadow, cfg_bg, t);
    endfunction

    class color_board;
        logic [23:0] pending[$];
        function void note_pixel(input logic [23:0] c);
            pending.push_back(c);
        endfunction
        task check_color(input logic [23:0] got);
            logic [23:0] want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected color %06h", got));
                return;
            end
            want = pending.pop_front();
            if (got !== want) report($sformatf("color %06h, expected %06h", got, want));
        endtask
    endclass

    color_board board = new();
    bit sink_idle_ok = 1'b1;
    bit src_idle_ok = 1'b1;
    int hold_cycles = 0;
    int quiet = 0;

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_BITS'(4 * idx); pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_RECT_WIDTH:       cfg_w = v[11:0];
            REG_RECT_HEIGHT:      cfg_h = v[11:0];
            REG_CORNER_RADIUS:    cfg_r = v[10:0];
            REG_SHADOW_WIDTH:     cfg_s = v[7:0];
            REG_FILL_COLOR:       cfg_fill = v[23:0];
            REG_SHADOW_COLOR:     cfg_shadow = v[23:0];
            default:              cfg_bg = v[23:0];
        endcase
    endtask

    task automatic setup(input int w, input int h, input int r, input int s,
                         input logic [23:0] f, input logic [23:0] sc, input logic [23:0] bg);
        write_reg(REG_RECT_WIDTH, w);
        write_reg(REG_RECT_HEIGHT, h);
        write_reg(REG_CORNER_RADIUS, r);
        write_reg(REG_SHADOW_WIDTH, s);
        write_reg(REG_FILL_COLOR, f);
        write_reg(REG_SHADOW_COLOR, sc);
        write_reg(REG_BACKGROUND_COLOR, bg);
    endtask

    // Offer one word and hold it until accepted; the prediction is made at acceptance.
    task automatic send_pixel(input int x, input int y);
        int gap;
        if (src_idle_ok && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_x <= COORD_BITS'(x);
        pixel_y <= COORD_BITS'(y);
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_pixel(shade_pixel(COORD_BITS'(x), COORD_BITS'(y)));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // Coordinates mostly near the rectangle and its shadow, some anywhere.
    task automatic send_random(input int n);
        int span, x, y;
        for (int i = 0; i < n; i++) begin
            span = int'(cfg_s) + 4;
            if ($urandom_range(0, 9) == 0) begin
                x = $urandom_range(0, 8191) - 4096;
                y = $urandom_range(0, 8191) - 4096;
            end else begin
                x = $urandom_range(0, cfg_w + 2 * span) - span;
                y = $urandom_range(0, cfg_h + 2 * span) - span;
                if (x > 4095) x = 4095;
                if (y > 4095) y = 4095;
            end
            send_pixel(x, y);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) board.check_color(pixel_color);
    end

    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (sink_idle_ok && !out_stall && $urandom_range(0, 7) == 0) begin
            out_stall <= 1'b1;
            hold_cycles <= $urandom_range(0, 11);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes of the coordinates, bands, corners and edges.
        setup(40, 30, 8, 10, 24'hff0000, 24'h00ff00, 24'h0000ff);
        send_pixel(0, 0);        send_pixel(20, 15);      send_pixel(-4096, -4096);
        send_pixel(4095, 4095);  send_pixel(-4096, 4095); send_pixel(20, -1);
        send_pixel(20, 30);      send_pixel(20, 31);      send_pixel(-1, 15);
        send_pixel(40, 15);      send_pixel(41, 15);      send_pixel(20, -5);
        send_pixel(-3, -3);      send_pixel(45, 35);      send_pixel(2, 2);
        send_pixel(20, -11);     send_pixel(7, 1);        send_pixel(-5000 + 8192, 10);
        drain();
        // Shadow disabled blends toward background.
        setup(16, 16, 3, 0, 24'h123456, 24'hffffff, 24'h00ff80);
        send_pixel(8, -1);       send_pixel(-1, -1);      send_pixel(8, 20);
        send_pixel(16, 16);      send_pixel(0, 0);
        drain();

        setup(4095, 4095, 2047, 255, 24'hffffff, 24'h000000, 24'hffffff);
        send_random(120);
        drain();
        setup(0, 0, 0, 255, 24'h000000, 24'hffffff, 24'h000000);
        send_random(80);
        drain();
        setup(20, 10, 30, 5, 24'hffffff, 24'habcdef, 24'h555555);
        send_random(150);
        drain();

        // Long receiver hold so that the pipeline fills and stalls the input.
        setup(64, 48, 12, 40, 24'h8040c0, 24'h203040, 24'hf0e0d0);
        hold_cycles = 200;
        send_random(150);
        drain();

        for (int k = 0; k < 5; k++) begin
            setup($urandom_range(0, 300), $urandom_range(0, 300), $urandom_range(0, 80),
                  $urandom_range(0, 255), $urandom_range(0, 24'hffffff),
                  $urandom_range(0, 24'hffffff), $urandom_range(0, 24'hffffff));
            send_random(130);
            drain();
        end

        src_idle_ok = 1'b0;
        sink_idle_ok = 1'b0;
        setup(100, 60, 20, 30, 24'hfedcba, 24'h102030, 24'h0a0b0c);
        send_random(150);
        drain();

        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
